// ----- hw/rtl/lkvc_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Field widths, access codes and result flag layout shared by the cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// read data returned by a lookup that misses
	localparam logic [VAL_W-1:0] READ_MISS = '1;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} opcode_t;

	// result flags as carried on m_tuser, found in bit 0
	typedef struct packed {
		logic evicted;
		logic found;
	} res_flags_t;

endpackage

// ----- hw/rtl/lru_key_value_cache_top.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache, top level
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//  - Accesses arrive on the s_ stream: s_tuser selects get or put, s_tdata
//    carries the key and, for a put, the value to store.
//  - Every access gives exactly one result transaction on the m_ stream:
//    found/evicted flags on m_tuser, read value and evicted key on m_tdata.
//  - Capacity is written on the cfg_ channel while the cache is idle; 0 acts
//    as 1 and values above ENTRIES act as ENTRIES.
//  - An accepted access is held in the s1 input register and its result in
//    the s2 result register. Throughput: one access per cycle while the
//    receiver does not stall; the tag compare, rank update and victim select
//    all sit between the s1 input register and the s2 result register.
//  - Each access updates the store as it moves into the result register, so
//    the next access always sees it.
//  - When the receiver stalls, the result holds in s2, the access behind it
//    waits in s1 and s_tready falls; nothing is lost.
//  - Reset empties the store (all entries invalid, ranks zero) and restores
//    a capacity of 16. Key and value storage is not cleared; it is only read
//    through valid entries.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top
	import lkvc_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CAP_W-1:0]       cfg_data,

	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [KEY_W+VAL_W-1:0] s_tdata,   // key[31:0], write_value[63:32]
	input  logic                   s_tuser,   // opcode

	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [VAL_W+KEY_W-1:0] m_tdata,   // read_value[31:0], evicted_key[63:32]
	output logic [1:0]             m_tuser    // found[0], evicted[1]
);

	localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;   // rank / index width
	localparam int CW = $clog2(ENTRIES + 1);                     // fill count width

	// ---- state ----
	logic [CAP_W-1:0] cap_q;
	logic [ENTRIES-1:0] valid_q;
	logic [RW-1:0] rank_q [ENTRIES];
	logic [KEY_W-1:0] key_q [ENTRIES];
	logic [VAL_W-1:0] val_q [ENTRIES];
	logic [CW-1:0] cnt_q;

	// ---- input register ----
	logic vld_s1;
	opcode_t op_s1;
	logic [KEY_W-1:0] key_s1;
	logic [VAL_W-1:0] wval_s1;

	// ---- result register ----
	logic vld_s2;
	res_flags_t flags_s2;
	logic [VAL_W-1:0] rval_s2;
	logic [KEY_W-1:0] evkey_s2;

	logic advance;

	assign cfg_ready = 1'b1;
	assign advance   = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready  = !vld_s1 || advance;

	assign m_tvalid = vld_s2;
	assign m_tdata  = {evkey_s2, rval_s2};
	assign m_tuser  = flags_s2;

	// ---- lookup and update ----
	logic [CW-1:0] eff_cap;
	logic [ENTRIES-1:0] match;
	logic hit;
	logic [RW-1:0] hit_idx;
	logic do_evict;
	logic [RW-1:0] vic_rank;
	logic [RW-1:0] vic_idx;
	logic [ENTRIES-1:0] valid_ev;
	logic slot_ok;
	logic [RW-1:0] slot_idx;
	logic is_put;
	logic ins;
	logic [ENTRIES-1:0] valid_d;
	logic [RW-1:0] rank_d [ENTRIES];
	logic [CW-1:0] cnt_d;
	res_flags_t flags_d;
	logic [VAL_W-1:0] rval_d;
	logic [KEY_W-1:0] evkey_d;

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (int'(cap_q) > ENTRIES) begin
			eff_cap = CW'(ENTRIES);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end

	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		vic_idx  = '0;
		slot_ok  = 1'b0;
		slot_idx = '0;
		vic_rank = RW'(cnt_q - CW'(1));
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == key_s1);
		end
		// lowest matching slot; keys of valid entries are distinct anyway
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit     = 1'b1;
				hit_idx = RW'(i);
			end
			if (valid_q[i] && rank_q[i] == vic_rank) begin
				vic_idx = RW'(i);
			end
		end

		is_put   = (op_s1 == OP_PUT);
		do_evict = is_put && !hit && (cnt_q != '0) && (cnt_q >= eff_cap);

		valid_ev = valid_q;
		if (do_evict) begin
			valid_ev[vic_idx] = 1'b0;
		end

		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_ev[i]) begin
				slot_ok  = 1'b1;
				slot_idx = RW'(i);
			end
		end
		ins = is_put && !hit && slot_ok;

		// next ranks and valid bits
		valid_d = valid_ev;
		cnt_d   = cnt_q;
		for (int i = 0; i < ENTRIES; i++) begin
			rank_d[i] = rank_q[i];
		end
		if (hit) begin
			// promote: fresher entries age by one
			for (int i = 0; i < ENTRIES; i++) begin
				if (valid_q[i] && rank_q[i] < rank_q[hit_idx]) begin
					rank_d[i] = rank_q[i] + RW'(1);
				end
			end
			rank_d[hit_idx] = '0;
		end else if (ins) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (valid_ev[i]) begin
					rank_d[i] = rank_q[i] + RW'(1);
				end
			end
			if (do_evict) begin
				rank_d[vic_idx] = '0;
			end
			rank_d[slot_idx]  = '0;
			valid_d[slot_idx] = 1'b1;
			if (!do_evict) begin
				cnt_d = cnt_q + CW'(1);
			end
		end else if (do_evict) begin
			rank_d[vic_idx] = '0;
			cnt_d = cnt_q - CW'(1);
		end

		flags_d.found   = hit;
		flags_d.evicted = do_evict;
		evkey_d = do_evict ? key_q[vic_idx] : '0;
		if (is_put) begin
			rval_d = wval_s1;
		end else if (hit) begin
			rval_d = val_q[hit_idx];
		end else begin
			rval_d = READ_MISS;
		end
	end

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			valid_q <= '0;
			cnt_q   <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (s_tvalid && s_tready) begin
				vld_s1 <= 1'b1;
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (advance) begin
				vld_s2 <= 1'b1;
			end else if (m_tready) begin
				vld_s2 <= 1'b0;
			end
			if (advance) begin
				valid_q <= valid_d;
				cnt_q   <= cnt_d;
				for (int i = 0; i < ENTRIES; i++) begin
					rank_q[i] <= rank_d[i];
				end
			end
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= opcode_t'(s_tuser);
			key_s1  <= s_tdata[KEY_W-1:0];
			wval_s1 <= s_tdata[KEY_W+VAL_W-1:KEY_W];
		end
		if (advance) begin
			flags_s2 <= flags_d;
			rval_s2  <= rval_d;
			evkey_s2 <= evkey_d;
			if (hit && is_put) begin
				val_q[hit_idx] <= wval_s1;
			end else if (ins) begin
				key_q[slot_idx] <= key_s1;
				val_q[slot_idx] <= wval_s1;
			end
		end
	end

	// ---- assertions ----
	logic ranks_ok;

	always_comb begin
		ranks_ok = 1'b1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (valid_q[i] && CW'(rank_q[i]) >= cnt_q) begin
				ranks_ok = 1'b0;
			end
		end
	end

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) == $countones(valid_q))
		else $error("fill count disagrees with valid bits");

	a_ranks: assert property (@(posedge clk) disable iff (!arst_n) ranks_ok)
		else $error("valid entry holds a rank at or above the fill count");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("hit reported together with eviction");

	a_evkey: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[1]) |-> (m_tdata[VAL_W+KEY_W-1:VAL_W] == '0))
		else $error("evicted key nonzero without eviction");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && ins && !do_evict) |=> (cnt_q == $past(cnt_q) + CW'(1)))
		else $error("insert without eviction did not grow the store");

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Sends get and put transactions under random flow control on both streams,
// keeps a shadow copy of the LRU store and checks every reply field by field.
// ----------------------------------------------------------------------------
module testbench;
	import lkvc_pkg::*;

	localparam int ENTRIES        = 16;
	localparam int RANK_W         = $clog2(ENTRIES);
	localparam int PIPE_LATENCY   = 2;     // access accepted -> reply valid
	localparam int LONG_HOLD      = 240;   // receiver hold-off, in cycles
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
	localparam int MAX_PRINTED    = 40;    // mismatch lines printed, rest only counted
	localparam int PHASE_ITEMS    = 225;

	// one reply of the cache, unpacked
	typedef struct packed {
		logic             found;
		logic [VAL_W-1:0] read_value;
		logic             evicted;
		logic [KEY_W-1:0] evicted_key;
	} cache_reply_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CAP_W-1:0]       cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [KEY_W+VAL_W-1:0] s_tdata;   // key[31:0], write_value[63:32]
	logic                   s_tuser;   // opcode
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [VAL_W+KEY_W-1:0] m_tdata;   // read_value[31:0], evicted_key[63:32]
	logic [1:0]             m_tuser;   // found[0], evicted[1]

	lru_key_value_cache_top #(.ENTRIES(ENTRIES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// 12 unit period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow of the store: keys, values, valid flags, age ranks (0 = newest)
	logic [KEY_W-1:0]  ent_key   [ENTRIES];
	logic [VAL_W-1:0]  ent_value [ENTRIES];
	logic              ent_used  [ENTRIES];
	logic [RANK_W-1:0] ent_rank  [ENTRIES];
	logic [CAP_W-1:0]  used_count;
	logic [CAP_W-1:0]  capacity_setting;

	cache_reply_t replies_due [$];

	int unsigned error_count   = 0;
	int unsigned items_sent    = 0;
	int unsigned hit_count     = 0;
	int unsigned miss_count    = 0;
	int unsigned evict_count   = 0;
	int unsigned cfg_writes    = 0;
	int unsigned rx_stall      = 0;
	int unsigned hold_request  = 0;
	int unsigned quiet_cycles  = 0;
	bit          steady_flow   = 1'b0;  // no random gaps on either side while set

	// mostly short, a few long
	function automatic int unsigned rand_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// move one entry to rank 0; everything fresher than it ages by one
	function automatic void make_newest(int idx);
		int i;
		for (i = 0; i < ENTRIES; i++)
			if (ent_used[i] && ent_rank[i] < ent_rank[idx])
				ent_rank[i]++;
		ent_rank[idx] = '0;
	endfunction

	// apply one access to the shadow store and return the reply it must give
	function automatic cache_reply_t apply_access(opcode_t op, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v);
		cache_reply_t     r;
		int               i;
		int               hit;
		int               slot;
		logic [CAP_W-1:0] limit;
		r     = '0;
		hit   = -1;
		slot  = -1;
		limit = (capacity_setting == 0) ? CAP_W'(1) :
			(capacity_setting > ENTRIES) ? CAP_W'(ENTRIES) : capacity_setting;
		for (i = 0; i < ENTRIES; i++)
			if (hit < 0 && ent_used[i] && ent_key[i] == k)
				hit = i;
		if (op == OP_GET) begin
			r.read_value = READ_MISS;
			if (hit >= 0) begin
				r.found      = 1'b1;
				r.read_value = ent_value[hit];
				make_newest(hit);
			end
		end else if (hit >= 0) begin
			r.found        = 1'b1;
			r.read_value   = v;
			ent_value[hit] = v;
			make_newest(hit);
		end else begin
			r.read_value = v;
			// full, or over-full after a capacity cut: only the single oldest goes
			if (used_count >= limit && used_count != 0)
				for (i = 0; i < ENTRIES; i++)
					if (!r.evicted && ent_used[i] && ent_rank[i] == used_count - 1) begin
						r.evicted     = 1'b1;
						r.evicted_key = ent_key[i];
						ent_used[i]   = 1'b0;
						ent_rank[i]   = '0;
						used_count--;
					end
			for (i = 0; i < ENTRIES; i++)
				if (slot < 0 && !ent_used[i])
					slot = i;
			if (slot >= 0) begin
				for (i = 0; i < ENTRIES; i++)
					if (ent_used[i])
						ent_rank[i]++;
				ent_used[slot]  = 1'b1;
				ent_key[slot]   = k;
				ent_value[slot] = v;
				ent_rank[slot]  = '0;
				used_count++;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (error_count < MAX_PRINTED)
			$display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
		error_count++;
	endtask

	// One access on the s_ stream. Valid is left high after acceptance; the
	// next call either replaces the data at the next falling edge or lowers
	// valid there for a gap, so valid never toggles within one time step.
	task automatic send_access(opcode_t op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
		int unsigned gap;
		gap = steady_flow ? 0 : rand_gap();
		if (gap != 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {v, k};
		do @(posedge clk); while (!s_tready);
		replies_due.push_back(apply_access(op, k, v));
		items_sent++;
	endtask

	// stop offering, let every reply come back, then allow the pipeline to settle
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] value);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		capacity_setting = value;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Receiver: random stalls, plus one long hold-off when a test asks for it.
	always @(negedge clk) begin
		if (rx_stall != 0) begin
			m_tready <= 1'b0;
			rx_stall <= rx_stall - 1;
		end else if (hold_request != 0) begin
			m_tready     <= 1'b0;
			rx_stall     <= hold_request - 1;
			hold_request = 0;
		end else if (!steady_flow && $urandom_range(0, 99) < 20) begin
			m_tready <= 1'b0;
			rx_stall <= rand_gap();
		end else
			m_tready <= 1'b1;
	end

	// Reply checker: each accepted result against the oldest expectation.
	cache_reply_t seen_reply;
	cache_reply_t due_reply;
	res_flags_t   seen_flags;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_flags              = m_tuser;
			seen_reply.found        = seen_flags.found;
			seen_reply.evicted      = seen_flags.evicted;
			seen_reply.read_value   = m_tdata[VAL_W-1:0];
			seen_reply.evicted_key  = m_tdata[VAL_W+KEY_W-1:VAL_W];
			if (replies_due.size() == 0)
				report_mismatch("reply with nothing outstanding", seen_reply.read_value, '0);
			else begin
				due_reply = replies_due.pop_front();
				if (seen_reply.found !== due_reply.found)
					report_mismatch("found", seen_reply.found, due_reply.found);
				if (seen_reply.read_value !== due_reply.read_value)
					report_mismatch("read_value", seen_reply.read_value, due_reply.read_value);
				if (seen_reply.evicted !== due_reply.evicted)
					report_mismatch("evicted", seen_reply.evicted, due_reply.evicted);
				if (seen_reply.evicted_key !== due_reply.evicted_key)
					report_mismatch("evicted_key", seen_reply.evicted_key,
						due_reply.evicted_key);
				if (due_reply.found)
					hit_count++;
				else
					miss_count++;
				if (due_reply.evicted)
					evict_count++;
			end
		end
	end

	// Watchdog: any transaction on any channel clears the count.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: %0d cycles without a transaction, %0d replies outstanding",
				quiet_cycles, replies_due.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// Reset capacity: hits and misses, extreme keys and values, in-place update.
	task automatic test_basic_access();
		send_access(OP_GET, 32'h0000_0000, 32'h0000_0000);  // empty store
		send_access(OP_PUT, 32'h0000_0000, 32'h7FFF_FFFF);
		send_access(OP_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
		send_access(OP_GET, 32'hFFFF_FFFF, 32'h1234_5678);  // value ignored on a get
		send_access(OP_GET, 32'h0000_0000, 32'h0000_0000);
		send_access(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);  // update in place
		send_access(OP_GET, 32'h0000_0000, 32'h0000_0000);  // hit that reads back -1
		send_access(OP_GET, 32'hA5A5_5A5A, 32'h0000_0000);
	endtask

	// Capacity cut below the number held: each new key evicts one, count stays.
	task automatic test_shrunk_capacity();
		write_capacity(CAP_W'(1));
		send_access(OP_PUT, 32'h0000_0005, 32'h0000_0055);
		send_access(OP_PUT, 32'h0000_0006, 32'h0000_0066);
		send_access(OP_GET, 32'h0000_0006, 32'h0000_0000);
		send_access(OP_PUT, 32'h0000_0006, 32'h0000_0067);  // hit: no eviction
		send_access(OP_GET, 32'h0000_0005, 32'h0000_0000);  // still held: each eviction took the oldest
		write_capacity(CAP_W'(2));
		send_access(OP_PUT, 32'h0000_0007, 32'h0000_0077);
		send_access(OP_GET, 32'h0000_0007, 32'h0000_0000);
	endtask

	// Full store at the largest capacity while the receiver holds off for a
	// long stretch: the pipeline fills and the input stalls with items waiting.
	task automatic test_full_store_backpressure();
		logic [KEY_W-1:0] keys [24];
		int               i;
		write_capacity(CAP_W'(16));
		for (i = 0; i < 24; i++)
			keys[i] = $urandom();
		steady_flow  = 1'b1;
		hold_request = LONG_HOLD;
		for (i = 0; i < 24; i++)
			send_access(OP_PUT, keys[i], $urandom());
		for (i = 0; i < 24; i++)
			send_access(OP_GET, keys[i], $urandom());
		steady_flow = 1'b0;
	endtask

	// Random phases across capacities, keys drawn mostly from a small pool so
	// that hits, updates and evictions are all frequent.
	task automatic test_random_traffic();
		logic [CAP_W-1:0] caps [8];
		logic [KEY_W-1:0] pool [$];
		logic [KEY_W-1:0] recent [$];
		logic [KEY_W-1:0] k;
		opcode_t          op;
		int unsigned      roll;
		int               p;
		int               n;
		caps = '{CAP_W'(16), CAP_W'(1), CAP_W'(3), CAP_W'(8), CAP_W'(15), CAP_W'(2),
			CAP_W'(16), CAP_W'(1)};
		caps[7] = CAP_W'($urandom_range(1, 16));
		for (p = 0; p < 8; p++) begin
			write_capacity(caps[p]);
			steady_flow = (p == 6);
			pool.delete();
			recent.delete();
			pool.push_back(32'h0000_0000);
			pool.push_back(32'hFFFF_FFFF);
			repeat (caps[p] + $urandom_range(1, caps[p] + 3))
				pool.push_back($urandom());
			for (n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 70)
					k = pool[$urandom_range(0, pool.size() - 1)];
				else if (roll < 88 && recent.size() != 0)
					k = recent[$urandom_range(0, recent.size() - 1)];
				else
					k = $urandom();
				op = opcode_t'($urandom_range(0, 1));
				send_access(op, k, $urandom());
				recent.push_back(k);
				if (recent.size() > 4)
					void'(recent.pop_front());
			end
		end
		steady_flow = 1'b0;
	endtask

	initial begin
		int i;
		arst_n           = 1'b0;
		cfg_valid        = 1'b0;
		cfg_data         = '0;
		s_tvalid         = 1'b0;
		s_tdata          = '0;
		s_tuser          = OP_GET;
		capacity_setting = CAP_RESET;
		used_count       = '0;
		for (i = 0; i < ENTRIES; i++) begin
			ent_key[i]   = '0;
			ent_value[i] = '0;
			ent_used[i]  = 1'b0;
			ent_rank[i]  = '0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_basic_access();
		test_shrunk_capacity();
		test_full_store_backpressure();
		test_random_traffic();
		wait_idle();
		repeat (PIPE_LATENCY + 2) @(posedge clk);

		$display("Ran %0d accesses over %0d capacity writes: %0d hits, %0d misses, %0d evictions.",
			items_sent, cfg_writes, hit_count, miss_count, evict_count);
		$display("Included a %0d-cycle receiver hold-off with the sender still offering; %0d mismatches.",
			LONG_HOLD, error_count);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
